// File: hw/rtl/asrs_pkg.sv
// Shared constants, register codes and record types of the averaged sensor range scaler.
// No dependencies; all other files of the block import this package.
package asrs_pkg;

  localparam int WINDOW      = 8;   // power of two, mean is a shift
  localparam int CHANNELS    = 2;
  localparam int SAMPLE_BITS = 12;
  localparam int DIST_W      = 16;
  localparam int CH_W        = 1;

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int SUM_W  = SAMPLE_BITS + SLOT_W;
  localparam int ADDR_W = CH_W + SLOT_W;
  localparam int DEPTH  = CHANNELS * WINDOW;

  localparam int PROD_W    = SAMPLE_BITS + DIST_W;
  localparam int DIV_BITS  = 4;
  localparam int DIV_ITERS = (PROD_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DVD_W     = DIV_ITERS * DIV_BITS;
  localparam int DCNT_W    = $clog2(DIV_ITERS + 1);
  localparam int V_W       = PROD_W + 2;

  localparam int CFG_IDX_W = 4;
  localparam int NUM_REGS  = 4 * CHANNELS;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 3;
  localparam int OUT_PAD_W   = OUT_TDATA_W - DIST_W - SAMPLE_BITS;

  localparam logic [SAMPLE_BITS-1:0] LOW_CODE_RST  = 12'd18;
  localparam logic [SAMPLE_BITS-1:0] HIGH_CODE_RST = 12'd3036;
  localparam logic [DIST_W-1:0]      NEAR_DIST_RST = 16'd200;
  localparam logic [DIST_W-1:0]      FAR_DIST_RST  = 16'd5000;

  typedef enum logic [1:0] {
    REG_LOW  = 2'd0,
    REG_HIGH = 2'd1,
    REG_NEAR = 2'd2,
    REG_FAR  = 2'd3
  } reg_sel_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] low_code;
    logic [SAMPLE_BITS-1:0] high_code;
    logic [DIST_W-1:0]      near_dist;
    logic [DIST_W-1:0]      far_dist;
  } chan_cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]        ch;
    logic [SAMPLE_BITS-1:0] mean;
  } win_res_t;

  typedef struct packed {
    logic [CH_W-1:0]        ch;
    logic [SAMPLE_BITS-1:0] mean;
    logic [DIST_W-1:0]      distance;
    logic                   below;
    logic                   clamped;
  } cal_res_t;

endpackage

// File: hw/rtl/asrs_window.sv
// Per-channel moving-average window: sample memory, running sums and slot pointers.
// Depends on asrs_pkg.
module asrs_window import asrs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [CH_W-1:0]        start_ch,
  input  logic [SAMPLE_BITS-1:0] start_sample,
  output logic                   res_valid,
  output win_res_t               res
);

  typedef enum logic [3:0] {
    W_IDLE = 4'b0001,
    W_FILL = 4'b0010,
    W_READ = 4'b0100,
    W_UPD  = 4'b1000
  } wstate_t;

  wstate_t state, state_next;

  logic [SAMPLE_BITS-1:0] mem [DEPTH];
  logic [SAMPLE_BITS-1:0] rdata;
  logic [SUM_W-1:0]       sum [CHANNELS];
  logic [SLOT_W-1:0]      slot [CHANNELS];
  logic [CHANNELS-1:0]    primed;
  logic [CH_W-1:0]        ch;
  logic [SAMPLE_BITS-1:0] sample;
  logic [SLOT_W-1:0]      fill_cnt;
  logic [CH_W-1:0]        ch_in;
  logic [SUM_W-1:0]       sum_upd;
  logic                   we;
  logic [ADDR_W-1:0]      waddr;
  logic                   fill_last;

  assign ch_in = (int'(start_ch) >= CHANNELS) ? CH_W'(CHANNELS - 1) : start_ch;
  assign sum_upd = sum[ch] - SUM_W'(rdata) + SUM_W'(sample);
  assign fill_last = (fill_cnt == SLOT_W'(WINDOW - 1));
  assign we = (state == W_FILL) || (state == W_UPD);
  assign waddr = (state == W_FILL) ? {ch, fill_cnt} : {ch, slot[ch]};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= sample;
    end
    if (state == W_READ) begin
      rdata <= mem[{ch, slot[ch]}];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      W_IDLE: begin
        if (start) begin
          state_next = primed[ch_in] ? W_READ : W_FILL;
        end
      end
      W_FILL: begin
        if (fill_last) begin
          state_next = W_IDLE;
        end
      end
      W_READ:  state_next = W_UPD;
      W_UPD:   state_next = W_IDLE;
      default: state_next = W_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= W_IDLE;
      primed    <= '0;
      res_valid <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        sum[c]  <= '0;
        slot[c] <= '0;
      end
    end else begin
      state     <= state_next;
      res_valid <= 1'b0;
      case (state)
        W_IDLE: begin
          if (start) begin
            ch       <= ch_in;
            sample   <= start_sample;
            fill_cnt <= '0;
          end
        end
        W_FILL: begin
          fill_cnt <= fill_cnt + SLOT_W'(1);
          if (fill_last) begin
            sum[ch]    <= SUM_W'(sample) << SLOT_W;
            slot[ch]   <= '0;
            primed[ch] <= 1'b1;
            res_valid  <= 1'b1;
            res.ch     <= ch;
            res.mean   <= sample;
          end
        end
        W_UPD: begin
          sum[ch]   <= sum_upd;
          slot[ch]  <= slot[ch] + SLOT_W'(1);
          res_valid <= 1'b1;
          res.ch    <= ch;
          res.mean  <= sum_upd[SUM_W-1 -: SAMPLE_BITS];
        end
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/asrs_div.sv
// Iterative unsigned divider, DIV_BITS quotient bits per cycle (restoring).
// Depends on asrs_pkg.
module asrs_div import asrs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [DVD_W-1:0]       dividend,
  input  logic [SAMPLE_BITS-1:0] divisor,
  output logic                   done,
  output logic [DVD_W-1:0]       quotient
);

  logic                   busy;
  logic [DCNT_W-1:0]      cnt;
  logic [SAMPLE_BITS-1:0] rem;
  logic [SAMPLE_BITS-1:0] dsr;
  logic [DVD_W-1:0]       acc;
  logic [SAMPLE_BITS-1:0] rem_next;
  logic [DVD_W-1:0]       acc_next;
  logic [SAMPLE_BITS:0]   trial;

  always_comb begin
    rem_next = rem;
    acc_next = acc;
    trial    = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial    = {rem_next, acc_next[DVD_W-1]};
      acc_next = {acc_next[DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        trial       = trial - {1'b0, dsr};
        acc_next[0] = 1'b1;
      end
      rem_next = trial[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(DIV_ITERS);
        acc  <= dividend;
        rem  <= '0;
        dsr  <= divisor;
      end else if (busy) begin
        acc <= acc_next;
        rem <= rem_next;
        cnt <= cnt - DCNT_W'(1);
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = acc;

endmodule

// File: hw/rtl/asrs_cal.sv
// Linear calibration of a window mean: range checks, span multiply, divide, clamp.
// Depends on asrs_pkg and asrs_div.
module asrs_cal import asrs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  win_res_t  win,
  input  chan_cfg_t cfg,
  input  logic      take,
  output logic      res_valid,
  output cal_res_t  res
);

  typedef enum logic [6:0] {
    C_IDLE = 7'b0000001,
    C_PREP = 7'b0000010,
    C_MUL  = 7'b0000100,
    C_DGO  = 7'b0001000,
    C_DIV  = 7'b0010000,
    C_FIN  = 7'b0100000,
    C_HOLD = 7'b1000000
  } cstate_t;

  cstate_t state, state_next;

  logic [CH_W-1:0]        ch;
  logic [SAMPLE_BITS-1:0] mean;
  chan_cfg_t              cf;
  logic                   below;
  logic                   zspan;
  logic                   neg;
  logic [SAMPLE_BITS-1:0] dm;
  logic [DIST_W-1:0]      dd_mag;
  logic [SAMPLE_BITS-1:0] dc_mag;
  logic [PROD_W-1:0]      prod;
  logic [PROD_W-1:0]      quo;

  logic                      below_c;
  logic                      zspan_c;
  logic signed [DIST_W:0]    dd;
  logic signed [SAMPLE_BITS:0] dc;
  logic                      div_start;
  logic                      div_done;
  logic [DVD_W-1:0]          div_q;
  logic signed [V_W-1:0]     sq;
  logic signed [V_W-1:0]     v;
  logic                      v_ge_far;

  assign below_c = (mean < cf.low_code);
  assign zspan_c = (cf.high_code == cf.low_code);
  assign dd = $signed({1'b0, cf.far_dist}) - $signed({1'b0, cf.near_dist});
  assign dc = $signed({1'b0, cf.high_code}) - $signed({1'b0, cf.low_code});
  assign div_start = (state == C_DGO);

  assign sq = neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
  assign v = sq + $signed(V_W'(cf.near_dist));
  assign v_ge_far = (v >= $signed(V_W'(cf.far_dist)));

  asrs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (DVD_W'(prod)),
    .divisor  (dc_mag),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      C_IDLE: begin
        if (start) begin
          state_next = C_PREP;
        end
      end
      C_PREP:  state_next = (below_c || zspan_c) ? C_FIN : C_MUL;
      C_MUL:   state_next = C_DGO;
      C_DGO:   state_next = C_DIV;
      C_DIV: begin
        if (div_done) begin
          state_next = C_FIN;
        end
      end
      C_FIN:   state_next = C_HOLD;
      C_HOLD: begin
        if (take) begin
          state_next = C_IDLE;
        end
      end
      default: state_next = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= C_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        C_IDLE: begin
          if (start) begin
            ch   <= win.ch;
            mean <= win.mean;
            cf   <= cfg;
          end
        end
        C_PREP: begin
          below  <= below_c;
          zspan  <= zspan_c;
          dm     <= mean - cf.low_code;
          dd_mag <= dd[DIST_W] ? DIST_W'(-dd) : dd[DIST_W-1:0];
          dc_mag <= dc[SAMPLE_BITS] ? SAMPLE_BITS'(-dc) : dc[SAMPLE_BITS-1:0];
          neg    <= dd[DIST_W] ^ dc[SAMPLE_BITS];
        end
        C_MUL: begin
          prod <= PROD_W'(dm) * PROD_W'(dd_mag);
        end
        C_DIV: begin
          if (div_done) begin
            quo <= div_q[PROD_W-1:0];
          end
        end
        C_FIN: begin
          res_valid    <= 1'b1;
          res.ch       <= ch;
          res.mean     <= mean;
          res.below    <= below;
          res.clamped  <= 1'b0;
          res.distance <= '0;
          if (below) begin
            res.distance <= '0;
          end else if (zspan || v_ge_far) begin
            res.distance <= cf.far_dist;
            res.clamped  <= 1'b1;
          end else if (v[V_W-1]) begin
            res.distance <= '0;
          end else begin
            res.distance <= v[DIST_W-1:0];
          end
        end
        C_HOLD: begin
          if (take) begin
            res_valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/averaged_sensor_range_scaler_unit.sv
// Top level of the averaged sensor range scaler: stream ports, calibration registers, output stage.
// Depends on asrs_pkg, asrs_window and asrs_cal.
//
// Each sample word (tuser = channel, tdata = 12-bit code) updates that channel's 8-deep moving
// average held in a small sample memory, and one result word follows with the truncated mean
// and the distance mapped from [low_code, high_code] onto [near_dist, far_dist], clamped to
// far_dist at or above it or for a zero code span, and to 0 where it would fall below 0. One
// sample is processed at a time: an in-range sample goes through the window update, the span
// multiply and the divider, which resolves four quotient bits per cycle; a mean under low_code
// or a zero code span skips the multiply and divide. The first sample of each channel after
// reset also writes all 8 window slots, one per cycle. The next sample is taken as soon as the
// result sits in the output register, even if it is not yet read. Calibration writes are
// taken every cycle; indexes above 7 are ignored.
module averaged_sensor_range_scaler_unit import asrs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [11:0] sample
  input  logic [CH_W-1:0]        s_tuser,   // [0] channel
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [11:0] mean_code, [27:12] distance
  output logic [OUT_TUSER_W-1:0] m_tuser,   // [0] out_channel, [1] below_range, [2] clamped
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DIST_W-1:0]      cfg_data
);

  chan_cfg_t chan_cfg [CHANNELS];

  logic      busy;
  logic      in_acc;
  logic      win_valid;
  win_res_t  win_res;
  logic      cal_valid;
  cal_res_t  cal_res;
  logic      take;
  logic      out_valid;
  cal_res_t  out_res;
  logic [CH_W-1:0] cfg_ch;

  assign s_tready  = !busy;
  assign in_acc    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign cfg_ch    = cfg_index[2 +: CH_W];
  assign take      = cal_valid && (!out_valid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        chan_cfg[c].low_code  <= LOW_CODE_RST;
        chan_cfg[c].high_code <= HIGH_CODE_RST;
        chan_cfg[c].near_dist <= NEAR_DIST_RST;
        chan_cfg[c].far_dist  <= FAR_DIST_RST;
      end
    end else if (cfg_valid && (int'(cfg_index) < NUM_REGS)) begin
      case (reg_sel_t'(cfg_index[1:0]))
        REG_LOW:  chan_cfg[cfg_ch].low_code  <= cfg_data[SAMPLE_BITS-1:0];
        REG_HIGH: chan_cfg[cfg_ch].high_code <= cfg_data[SAMPLE_BITS-1:0];
        REG_NEAR: chan_cfg[cfg_ch].near_dist <= cfg_data;
        REG_FAR:  chan_cfg[cfg_ch].far_dist  <= cfg_data;
        default: ;
      endcase
    end
  end

  asrs_window u_window (
    .clk          (clk),
    .rst          (rst),
    .start        (in_acc),
    .start_ch     (s_tuser),
    .start_sample (s_tdata[SAMPLE_BITS-1:0]),
    .res_valid    (win_valid),
    .res          (win_res)
  );

  asrs_cal u_cal (
    .clk       (clk),
    .rst       (rst),
    .start     (win_valid),
    .win       (win_res),
    .cfg       (chan_cfg[win_res.ch]),
    .take      (take),
    .res_valid (cal_valid),
    .res       (cal_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        busy <= 1'b0;
      end else if (in_acc) begin
        busy <= 1'b1;
      end
      if (take) begin
        out_valid <= 1'b1;
        out_res   <= cal_res;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_res.distance, out_res.mean};
  assign m_tuser  = {out_res.clamped, out_res.below, out_res.ch};

endmodule

// File: hw/rtl/asrs_checker.sv
// Port-level checks for the averaged sensor range scaler, bound to its top level.
// Depends on asrs_pkg and averaged_sensor_range_scaler_unit.
module asrs_checker import asrs_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic [OUT_TUSER_W-1:0] m_tuser
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // one sample in flight
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second sample accepted while busy");

  // a new result only comes out of an accepted sample
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared with no sample in flight");

  // below range gives zero distance, never clamped
  a_below: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> (m_tdata[SAMPLE_BITS +: DIST_W] == '0) && !m_tuser[2])
    else $error("below-range result with distance or clamp set");

endmodule

bind averaged_sensor_range_scaler_unit asrs_checker u_asrs_checker (.*);
